[hdl/extended_gcd_signed_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the extended GCD block
// Short forms for clocked properties that are disabled during reset.
// ----------------------------------------------------------------------------
`ifndef EXTENDED_GCD_SIGNED_ASSERT_SVH
`define EXTENDED_GCD_SIGNED_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EGCD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define EGCD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/egcd_pkg.sv]
// ----------------------------------------------------------------------------
// egcd_pkg
// Widths, microcode types and the control store of the extended GCD block.
// ----------------------------------------------------------------------------
package egcd_pkg;

  localparam int WIDTH = 32;
  localparam int CW    = WIDTH + 1;
  // The alignment count reaches at most WIDTH.
  localparam int KW    = $clog2(WIDTH + 1);
  localparam int PC_W  = 4;

  typedef logic [PC_W-1:0] addr_t;

  localparam addr_t ADDR_FINISH = addr_t'(0);
  localparam addr_t ADDR_IDLE   = addr_t'(1);
  localparam addr_t ADDR_TEST   = addr_t'(2);
  localparam addr_t ADDR_DINIT  = addr_t'(3);
  localparam addr_t ADDR_ALIGN  = addr_t'(4);
  localparam addr_t ADDR_REDUCE = addr_t'(5);
  localparam addr_t ADDR_MUL_S  = addr_t'(6);
  localparam addr_t ADDR_UPD_S  = addr_t'(7);
  localparam addr_t ADDR_MUL_T  = addr_t'(8);
  localparam addr_t ADDR_UPD_T  = addr_t'(9);
  localparam addr_t ADDR_SWAP   = addr_t'(10);

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_DIV_INIT,
    OP_ALIGN,
    OP_REDUCE,
    OP_MUL_S,
    OP_UPD_S,
    OP_MUL_T,
    OP_UPD_T,
    OP_SWAP,
    OP_FINISH
  } op_t;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_BEAT,
    COND_B_ZERO,
    COND_ALIGN,
    COND_K_MORE,
    COND_OUT_BUSY
  } cond_t;

  // A taken condition loads the target; otherwise the step counter advances.
  typedef struct packed {
    op_t   op;
    cond_t cond;
    addr_t target;
  } ucode_t;

  function automatic ucode_t ucode_rom(input addr_t addr);
    ucode_t w;
    begin
      case (addr)
        ADDR_FINISH: w = '{op: OP_FINISH,   cond: COND_OUT_BUSY, target: ADDR_FINISH};
        ADDR_IDLE:   w = '{op: OP_LOAD,     cond: COND_NO_BEAT,  target: ADDR_IDLE};
        ADDR_TEST:   w = '{op: OP_NOP,      cond: COND_B_ZERO,   target: ADDR_FINISH};
        ADDR_DINIT:  w = '{op: OP_DIV_INIT, cond: COND_NEVER,    target: ADDR_IDLE};
        ADDR_ALIGN:  w = '{op: OP_ALIGN,    cond: COND_ALIGN,    target: ADDR_ALIGN};
        ADDR_REDUCE: w = '{op: OP_REDUCE,   cond: COND_K_MORE,   target: ADDR_REDUCE};
        ADDR_MUL_S:  w = '{op: OP_MUL_S,    cond: COND_NEVER,    target: ADDR_IDLE};
        ADDR_UPD_S:  w = '{op: OP_UPD_S,    cond: COND_NEVER,    target: ADDR_IDLE};
        ADDR_MUL_T:  w = '{op: OP_MUL_T,    cond: COND_NEVER,    target: ADDR_IDLE};
        ADDR_UPD_T:  w = '{op: OP_UPD_T,    cond: COND_NEVER,    target: ADDR_IDLE};
        ADDR_SWAP:   w = '{op: OP_SWAP,     cond: COND_ALWAYS,   target: ADDR_TEST};
        default:     w = '{op: OP_NOP,      cond: COND_ALWAYS,   target: ADDR_IDLE};
      endcase
      return w;
    end
  endfunction

endpackage

[hdl/extended_gcd_signed.sv]
// ----------------------------------------------------------------------------
// extended_gcd_signed
// Signed extended Euclid: gcd of |a| and |b| with Bezout coefficients.
// ----------------------------------------------------------------------------
// Usage: one input beat (value_a, value_b) on the in_valid/in_ready channel
// gives exactly one output beat (divisor, coeff_a, coeff_b) on the
// out_valid/out_ready channel, with value_a*coeff_a + value_b*coeff_b equal
// to divisor. Both operands zero give divisor 0, coeff_a +1, coeff_b 0.
// A microcode sequencer runs one Euclid step after another. Each step tests
// for a zero divisor and loads the divider, then runs a shift-and-subtract
// division that first aligns the divisor and then reduces the remainder,
// then performs the two coefficient updates on one shared multiplier and
// the operand swap. Once the result is written, the sequencer returns to
// idle to take the next input.
// One item is in flight at a time. The result sits in an output register, so
// the next operand pair is taken while that result still waits; a stalled
// receiver blocks the block only when the next result is ready to be written.
// Reset is synchronous and returns the sequencer to idle with no result held.
// ----------------------------------------------------------------------------
`include "extended_gcd_signed_assert.svh"

module extended_gcd_signed (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [egcd_pkg::WIDTH-1:0]     value_a,
  input  logic signed [egcd_pkg::WIDTH-1:0]     value_b,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic        [egcd_pkg::WIDTH-1:0]     divisor,
  output logic signed [egcd_pkg::CW-1:0]        coeff_a,
  output logic signed [egcd_pkg::CW-1:0]        coeff_b
);

  egcd_pkg::addr_t  pc;
  egcd_pkg::addr_t  pc_next;
  egcd_pkg::ucode_t uc;

  // Operand magnitudes with their signs.
  logic [egcd_pkg::WIDTH-1:0] ma;
  logic [egcd_pkg::WIDTH-1:0] mb;
  logic                       sa;
  logic                       sb;

  // Division unit.
  logic [egcd_pkg::WIDTH-1:0] rem;
  logic [egcd_pkg::CW-1:0]    dv;
  logic [egcd_pkg::CW-1:0]    dv_half;
  logic [egcd_pkg::WIDTH-1:0] qm;
  logic [egcd_pkg::KW-1:0]    k;
  logic                       align_go;
  logic                       reduce_go;

  // Coefficients of the current pair, kept modulo 2^CW.
  logic [egcd_pkg::CW-1:0]    s0;
  logic [egcd_pkg::CW-1:0]    s1;
  logic [egcd_pkg::CW-1:0]    t0;
  logic [egcd_pkg::CW-1:0]    t1;
  logic [egcd_pkg::CW-1:0]    mul_in;
  logic [egcd_pkg::CW-1:0]    prod_next;
  logic [egcd_pkg::CW-1:0]    prod;
  logic                       q_neg;

  logic in_beat;
  logic out_busy;
  logic take;

  assign uc        = egcd_pkg::ucode_rom(pc);
  assign in_ready  = (uc.op == egcd_pkg::OP_LOAD);
  assign in_beat   = in_valid && in_ready;
  assign out_busy  = out_valid && !out_ready;

  assign dv_half   = dv >> 1;
  assign align_go  = (dv <= {1'b0, rem});
  assign reduce_go = (k != '0);
  assign q_neg     = sa ^ sb;

  assign mul_in    = (uc.op == egcd_pkg::OP_MUL_T) ? t1 : s1;
  // Only the low CW bits of the product are needed, so sign does not matter.
  assign prod_next = mul_in * {1'b0, qm};

  always_comb begin
    case (uc.cond)
      egcd_pkg::COND_NEVER:    take = 1'b0;
      egcd_pkg::COND_ALWAYS:   take = 1'b1;
      egcd_pkg::COND_NO_BEAT:  take = !in_valid;
      egcd_pkg::COND_B_ZERO:   take = (mb == '0);
      egcd_pkg::COND_ALIGN:    take = align_go;
      egcd_pkg::COND_K_MORE:   take = (k > egcd_pkg::KW'(1));
      egcd_pkg::COND_OUT_BUSY: take = out_busy;
      default:                 take = 1'b0;
    endcase
    pc_next = take ? uc.target : pc + egcd_pkg::PC_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= egcd_pkg::ADDR_IDLE;
      out_valid <= 1'b0;
    end else begin
      pc <= pc_next;
      if ((uc.op == egcd_pkg::OP_FINISH) && !out_busy) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (uc.op)
      egcd_pkg::OP_LOAD: begin
        if (in_beat) begin
          sa <= value_a[egcd_pkg::WIDTH-1];
          sb <= value_b[egcd_pkg::WIDTH-1];
          ma <= value_a[egcd_pkg::WIDTH-1] ? -value_a : value_a;
          mb <= value_b[egcd_pkg::WIDTH-1] ? -value_b : value_b;
          s0 <= egcd_pkg::CW'(1);
          s1 <= '0;
          t0 <= '0;
          t1 <= egcd_pkg::CW'(1);
        end
      end
      egcd_pkg::OP_DIV_INIT: begin
        rem <= ma;
        dv  <= {1'b0, mb};
        qm  <= '0;
        k   <= '0;
      end
      egcd_pkg::OP_ALIGN: begin
        if (align_go) begin
          dv <= dv << 1;
          k  <= k + egcd_pkg::KW'(1);
        end
      end
      egcd_pkg::OP_REDUCE: begin
        if (reduce_go) begin
          dv <= dv_half;
          k  <= k - egcd_pkg::KW'(1);
          if ({1'b0, rem} >= dv_half) begin
            rem <= rem - dv_half[egcd_pkg::WIDTH-1:0];
            qm  <= {qm[egcd_pkg::WIDTH-2:0], 1'b1};
          end else begin
            qm  <= {qm[egcd_pkg::WIDTH-2:0], 1'b0};
          end
        end
      end
      egcd_pkg::OP_MUL_S, egcd_pkg::OP_MUL_T: begin
        prod <= prod_next;
      end
      egcd_pkg::OP_UPD_S: begin
        // The signed quotient is -qm when the operand signs differ.
        s0 <= s1;
        s1 <= q_neg ? s0 + prod : s0 - prod;
      end
      egcd_pkg::OP_UPD_T: begin
        t0 <= t1;
        t1 <= q_neg ? t0 + prod : t0 - prod;
      end
      egcd_pkg::OP_SWAP: begin
        // The truncated remainder takes the sign of the dividend.
        ma <= mb;
        sa <= sb;
        mb <= rem;
        sb <= sa;
      end
      egcd_pkg::OP_FINISH: begin
        if (!out_busy) begin
          divisor <= ma;
          coeff_a <= sa ? -s0 : s0;
          coeff_b <= sa ? -t0 : t0;
        end
      end
      default: begin
      end
    endcase
  end

  `EGCD_ASSERT_NEXT(a_beat_starts_chain, in_beat, pc == egcd_pkg::ADDR_TEST, "beat did not start the chain")
  `EGCD_ASSERT_SAME(a_rem_below_divisor, pc == egcd_pkg::ADDR_MUL_S, rem < mb, "remainder not below divisor")
  `EGCD_ASSERT_NEXT(a_finish_writes_result, (uc.op == egcd_pkg::OP_FINISH) && !out_busy, out_valid && (divisor == $past(ma)), "result not written at finish")

endmodule

[test/bezout_checker.sv]
// ----------------------------------------------------------------------------
// bezout_checker
// Watches both channels of the extended GCD block, predicts each result from
// the accepted operand pair and compares it field by field.
// ----------------------------------------------------------------------------
module bezout_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic signed [egcd_pkg::WIDTH-1:0] value_a,
  input  logic signed [egcd_pkg::WIDTH-1:0] value_b,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic        [egcd_pkg::WIDTH-1:0] divisor,
  input  logic signed [egcd_pkg::CW-1:0]    coeff_a,
  input  logic signed [egcd_pkg::CW-1:0]    coeff_b,
  output int                                mismatches,
  output int                                pending,
  output int                                checked
);

  localparam int CHAIN_MAX = 2 * egcd_pkg::WIDTH + 4;

  typedef struct packed {
    logic        [egcd_pkg::WIDTH-1:0] divisor;
    logic signed [egcd_pkg::CW-1:0]    coeff_a;
    logic signed [egcd_pkg::CW-1:0]    coeff_b;
  } bezout_t;

  bezout_t pending_results[$];

  // Remainder chain with truncating division, then the quotients are
  // unwound in reverse. Coefficient arithmetic wraps at 64 bits.
  function automatic bezout_t bezout_of(input logic signed [egcd_pkg::WIDTH-1:0] a_in,
                                        input logic signed [egcd_pkg::WIDTH-1:0] b_in);
    longint      num;
    longint      den;
    longint      rem;
    logic [63:0] quot[CHAIN_MAX];
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] nx;
    logic [63:0] mag;
    int          steps;
    bezout_t     res;
    num   = longint'(a_in);
    den   = longint'(b_in);
    steps = 0;
    while (den != 0 && steps < CHAIN_MAX) begin
      quot[steps] = num / den;
      rem         = num % den;
      steps++;
      num = den;
      den = rem;
    end
    // The sign of the last nonzero remainder sets the starting coefficient.
    x = (num >= 0) ? 64'd1 : '1;
    y = '0;
    for (int i = steps - 1; i >= 0; i--) begin
      nx = y;
      y  = x - y * quot[i];
      x  = nx;
    end
    mag         = (num < 0) ? 64'(-num) : 64'(num);
    res.divisor = mag[egcd_pkg::WIDTH-1:0];
    res.coeff_a = x[egcd_pkg::CW-1:0];
    res.coeff_b = y[egcd_pkg::CW-1:0];
    return res;
  endfunction

  always @(posedge clk) begin
    bezout_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        pending_results = {pending_results, bezout_of(value_a, value_b)};
      end
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result beat: divisor %0d coeff_a %0d coeff_b %0d",
                 divisor, coeff_a, coeff_b);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          checked++;
          if (divisor !== want.divisor) begin
            $error("divisor: expected %0d, actual %0d", want.divisor, divisor);
            mismatches++;
          end
          if (coeff_a !== want.coeff_a) begin
            $error("coeff_a: expected %0d, actual %0d", want.coeff_a, coeff_a);
            mismatches++;
          end
          if (coeff_b !== want.coeff_b) begin
            $error("coeff_b: expected %0d, actual %0d", want.coeff_b, coeff_b);
            mismatches++;
          end
        end
      end
      pending = pending_results.size();
    end
  end

endmodule

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives operand pairs into the extended GCD block with random gaps and
// receiver stalls; a checker beside the block predicts every result.
// ----------------------------------------------------------------------------
module testbench;

  localparam int RANDOM_PAIRS = 1200;
  localparam int DRAIN_CYCLES = 600;
  localparam int CYCLE_LIMIT  = 4_000_000;
  localparam int MOST_NEG     = 32'h8000_0000;
  localparam int MOST_POS     = 32'h7fff_ffff;

  logic                              clk       = 1'b0;
  logic                              rst       = 1'b1;
  logic                              in_valid  = 1'b0;
  logic                              in_ready;
  logic signed [egcd_pkg::WIDTH-1:0] value_a   = '0;
  logic signed [egcd_pkg::WIDTH-1:0] value_b   = '0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic        [egcd_pkg::WIDTH-1:0] divisor;
  logic signed [egcd_pkg::CW-1:0]    coeff_a;
  logic signed [egcd_pkg::CW-1:0]    coeff_b;

  int mismatches;
  int pending;
  int checked;
  int cycles    = 0;
  int sent      = 0;
  int directed  = 0;
  bit steady    = 1'b0;
  int fib[0:46];

  always #5 clk = ~clk;

  extended_gcd_signed DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .value_a   (value_a),
    .value_b   (value_b),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .divisor   (divisor),
    .coeff_a   (coeff_a),
    .coeff_b   (coeff_b)
  );

  bezout_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .value_a    (value_a),
    .value_b    (value_b),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .divisor    (divisor),
    .coeff_a    (coeff_a),
    .coeff_b    (coeff_b),
    .mismatches (mismatches),
    .pending    (pending),
    .checked    (checked)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic int flip_sign(input int v);
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  // Valid is kept high across back-to-back beats; it only drops for a gap.
  task automatic send_pair(input int a, input int b);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    value_a  <= a;
    value_b  <= b;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  // Receiver: holds ready low for a drawn number of cycles once a result shows.
  initial begin : result_drain
    int stall;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        out_ready <= 1'b0;
        do @(posedge clk); while (!out_valid);
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : stimulus
    int a;
    int b;
    int g;
    int idx;
    fib[0] = 0;
    fib[1] = 1;
    for (int i = 2; i <= 46; i++) fib[i] = fib[i-1] + fib[i-2];

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: both zero, single zero, most negative operands, longest chain.
    send_pair(0, 0);
    send_pair(0, 5);
    send_pair(5, 0);
    send_pair(0, -5);
    send_pair(-5, 0);
    send_pair(MOST_NEG, 0);
    send_pair(0, MOST_NEG);
    send_pair(MOST_NEG, MOST_NEG);
    send_pair(MOST_NEG, -1);
    send_pair(-1, MOST_NEG);
    send_pair(MOST_NEG, 2);
    send_pair(MOST_POS, MOST_POS);
    send_pair(MOST_POS, MOST_NEG);
    send_pair(MOST_NEG, MOST_POS);
    send_pair(MOST_POS, 1);
    send_pair(1, -1);
    send_pair(-1, -1);
    send_pair(fib[46], fib[45]);
    send_pair(-fib[45], fib[46]);
    send_pair(fib[45], -fib[46]);
    send_pair(12, -18);
    send_pair(-240, 46);
    send_pair(-7, -7);
    directed = sent;

    for (int n = 0; n < RANDOM_PAIRS; n++) begin
      if (n % 40 == 0) steady = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 7))
        0, 1: begin
          a = $urandom;
          b = $urandom;
        end
        2: begin
          g = $urandom_range(1, 65535);
          a = flip_sign(g * $urandom_range(0, 32767));
          b = flip_sign(g * $urandom_range(0, 32767));
        end
        3: begin
          idx = $urandom_range(2, 45);
          a   = flip_sign(fib[idx+1]);
          b   = flip_sign(fib[idx]);
          if ($urandom_range(0, 1)) begin
            g = a;
            a = b;
            b = g;
          end
        end
        4: begin
          a = flip_sign($urandom_range(0, 255));
          b = flip_sign($urandom_range(0, 255));
        end
        5: begin
          case ($urandom_range(0, 3))
            0:       a = 0;
            1:       a = flip_sign(1);
            2:       a = MOST_NEG;
            default: a = MOST_POS;
          endcase
          b = $urandom;
          if ($urandom_range(0, 1)) begin
            g = a;
            a = b;
            b = g;
          end
        end
        6: begin
          b = flip_sign($urandom_range(1, 65535));
          a = b * flip_sign($urandom_range(0, 32767));
        end
        default: begin
          a = $urandom;
          b = flip_sign(a);
        end
      endcase
      send_pair(a, b);
    end
    in_valid <= 1'b0;
    steady   = 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d operand pairs (%0d directed) and compared %0d results,",
             sent, directed, checked);
    $display("covering zero and extreme operands, shared factors and long chains.");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[extended_gcd_signed.f]
+incdir+hdl
hdl/egcd_pkg.sv
hdl/extended_gcd_signed.sv
test/bezout_checker.sv
test/testbench.sv
